>>> hw/rtl/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2
  } mpq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } mpq_status_e;

  // controller -> datapath
  typedef struct packed {
    logic            accept;      // input beat taken this cycle
    logic [OP_W-1:0] op;          // op of the beat being taken
    logic            rd_issue;    // read store at scan/shift pointer, advance pointer
    logic            shift_init;  // load pointer with min position + 1
    logic            shift_mode;  // returning reads are moved down one slot
    logic            cnt_dec;     // drop one entry
    logic            out_load;    // load result register
    logic            out_min;     // result carries the minimum found
  } mpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic scan_last;   // pointer sits on the last stored entry
    logic shift_more;  // pointer still below the count
    logic rd_pending;  // read data returns this cycle
    logic out_free;    // result register can take a new result
  } mpq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mpq_ram.sv
`default_nettype none

module mpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mpq_ctrl.sv
`default_nettype none

module mpq_ctrl
  import mpq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] in_op_i,
  input  wire mpq_stat_t       stat_i,
  output mpq_cmd_t             cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_INIT,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  mpq_op_e op_q, op_d;
  logic    take_min_q, take_min_d;
  logic    accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    take_min_d = take_min_q;
    cmd_o      = '0;
    cmd_o.op   = in_op_i;

    case (state_q)
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept) begin
          op_d       = mpq_op_e'(in_op_i);
          take_min_d = 1'b0;
          state_d    = S_DONE;
          if ((in_op_i inside {OP_DELETE, OP_PEEK}) && !stat_i.empty) begin
            take_min_d = 1'b1;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last compare lands at this edge
        state_d = (op_q == OP_DELETE) ? S_SHIFT_INIT : S_DONE;
      end
      S_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        state_d          = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift_mode = 1'b1;
        cmd_o.rd_issue   = stat_i.shift_more;
        if (!stat_i.shift_more && !stat_i.rd_pending) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_min = take_min_q;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_INSERT;
      take_min_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      take_min_q <= take_min_d;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded over an untaken result");

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !stat_i.empty)
    else $error("scan running on an empty store");

endmodule

`default_nettype wire

>>> hw/rtl/mpq_dp.sv
`default_nettype none

module mpq_dp
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mpq_cmd_t           cmd_i,
  output mpq_stat_t               stat_o,
  input  wire logic [VALUE_W-1:0] in_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VALUE_W-1:0]      out_value_o,
  output logic [STATUS_W-1:0]     out_status_o,
  output logic [COUNT_W-1:0]      out_count_o
);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_idx_q;
  logic [VALUE_W-1:0]  best_val_q;
  logic [AW-1:0]       best_idx_q;
  mpq_status_e         st_q, st_d;

  logic                out_vld_q;
  logic [VALUE_W-1:0]  out_val_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  logic                empty, full;
  logic                ins_wr, shift_wr, take;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  rd_data;

  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(CAPACITY));

  assign ins_wr   = cmd_i.accept & (cmd_i.op == OP_INSERT) & !full;
  assign shift_wr = cmd_i.shift_mode & rd_vld_q;

  assign ram_we    = ins_wr | shift_wr;
  assign ram_waddr = shift_wr ? AW'(rd_idx_q - AW'(1)) : count_q[AW-1:0];
  assign ram_wdata = shift_wr ? rd_data : in_value_i;

  mpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // first beat of a scan always wins; strict less keeps the lowest index on ties
  assign take = rd_vld_q & !cmd_i.shift_mode &
                ((rd_idx_q == '0) || ($signed(rd_data) < $signed(best_val_q)));

  always_comb begin
    count_d = count_q;
    if (ins_wr) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end

    ptr_d = ptr_q;
    if (cmd_i.accept) begin
      ptr_d = '0;
    end else if (cmd_i.shift_init) begin
      ptr_d = CNT_W'(best_idx_q) + CNT_W'(1);
    end else if (cmd_i.rd_issue) begin
      ptr_d = ptr_q + CNT_W'(1);
    end

    st_d = st_q;
    if (cmd_i.accept) begin
      case (cmd_i.op)
        OP_INSERT:          st_d = full ? ST_OVERFLOW : ST_OK;
        OP_DELETE, OP_PEEK: st_d = empty ? ST_EMPTY : ST_OK;
        default:            st_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      st_q      <= ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= cmd_i.rd_issue;
      st_q     <= st_d;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_idx_q <= ptr_q[AW-1:0];
    end
    if (take) begin
      best_val_q <= rd_data;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.out_load) begin
      out_val_q <= cmd_i.out_min ? best_val_q : '0;
      out_st_q  <= st_q;
      out_cnt_q <= COUNT_W'(count_q);
    end
  end

  assign stat_o.empty      = empty;
  assign stat_o.scan_last  = (ptr_q == count_q - CNT_W'(1));
  assign stat_o.shift_more = (ptr_q < count_q);
  assign stat_o.rd_pending = rd_vld_q;
  assign stat_o.out_free   = !out_vld_q | out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_value_o  = out_val_q;
  assign out_status_o = out_st_q;
  assign out_count_o  = out_cnt_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (!empty && !ins_wr))
    else $error("entry removed from an empty store");

endmodule

`default_nettype wire

>>> hw/rtl/min_priority_queue_scan.sv
`default_nettype none

// Min-priority queue over an unsorted store kept in arrival order. Each input
// beat carries one op in tuser: insert appends tdata at the tail (overflow
// status when full), delete-min removes the smallest signed value (lowest index
// wins a tie) and closes the gap so arrival order is kept, peek returns the
// minimum and leaves the store alone. Delete or peek on an empty queue gives
// empty status; an unused op code does nothing. Every beat yields exactly one
// result beat with the value (zero unless a minimum is returned), status and
// the entry count after the op. One op is in flight at a time, but a new op is
// taken while the previous result still waits on the output. The single read
// port of the entry RAM sets the pace: the min search reads one entry per cycle,
// then the shift down moves one entry per cycle. Store contents need no clearing
// after reset; only the count is reset.
module min_priority_queue_scan
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF  // 2..255 entries (entry_count is 8 bits)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [VALUE_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  wire logic [OP_W-1:0]     s_axis_tuser_i,   // [1:0] op
  // result channel
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [VALUE_W+COUNT_W-1:0] m_axis_tdata_o, // [31:0] result_value, [39:32] entry_count
  output logic [STATUS_W-1:0]      m_axis_tuser_o    // [1:0] status
);

  mpq_cmd_t           cmd;
  mpq_stat_t          stat;
  logic [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0] out_count;

  // sequencer: scan / shift / result handoff
  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // entry RAM, count, min tracker and result register
  mpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_value_i   (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (m_axis_tuser_o),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata_o = {out_count, out_value};

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench
  import mpq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP       = CAPACITY_DEF;
  // op code that the package leaves unused; the block must treat it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // drain wait after the last beat
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 20;
  // cycles with no beat on either side before the run is declared hung
  localparam int unsigned HANG_LIMIT   = 20 * (2 * CAP + 5);
  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned MAX_PRINTED  = 40;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } traffic_mix_e;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } pq_outcome_t;

  // Shadow of the queue: mirrors the store and predicts one result per request.
  class pq_scoreboard;
    logic signed [VALUE_W-1:0] slots [CAP];
    int unsigned fill;
    pq_outcome_t awaited[$];
    int unsigned mismatches, printed;
    int unsigned n_insert, n_delete, n_peek, n_unused;
    int unsigned n_overflow, n_empty, n_full, n_results;

    function new();
      fill = 0;
      mismatches = 0;
      printed = 0;
      n_insert = 0;
      n_delete = 0;
      n_peek = 0;
      n_unused = 0;
      n_overflow = 0;
      n_empty = 0;
      n_full = 0;
      n_results = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
      pq_outcome_t o;
      int unsigned best;
      int unsigned k;
      o.value = '0;
      o.status = ST_OK;
      case (op)
        OP_INSERT: begin
          n_insert++;
          if (fill >= CAP) begin
            o.status = ST_OVERFLOW;
            n_overflow++;
          end else begin
            slots[fill] = value;
            fill++;
            if (fill == CAP) n_full++;
          end
        end
        OP_DELETE, OP_PEEK: begin
          if (op == OP_DELETE) n_delete++;
          else n_peek++;
          if (fill == 0) begin
            o.status = ST_EMPTY;
            n_empty++;
          end else begin
            // first smallest entry wins a tie
            best = 0;
            for (k = 1; k < fill; k++) begin
              if (slots[k] < slots[best]) best = k;
            end
            o.value = slots[best];
            if (op == OP_DELETE) begin
              for (k = best; k + 1 < fill; k++) slots[k] = slots[k + 1];
              fill--;
            end
          end
        end
        default: n_unused++;
      endcase
      o.count = COUNT_W'(fill);
      awaited.push_back(o);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("%t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
      end
    endtask

    task check_result(logic [VALUE_W+COUNT_W-1:0] data, logic [STATUS_W-1:0] status);
      pq_outcome_t want;
      n_results++;
      if (awaited.size() == 0) begin
        report("unexpected result beat", {24'd0, data}, '0);
      end else begin
        want = awaited.pop_front();
        if (data[VALUE_W-1:0] !== want.value)
          report("result_value", 64'(data[VALUE_W-1:0]), 64'(want.value));
        if (data[VALUE_W +: COUNT_W] !== want.count)
          report("entry_count", 64'(data[VALUE_W +: COUNT_W]), 64'(want.count));
        if (status !== want.status)
          report("status", 64'(status), 64'(want.status));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [VALUE_W-1:0]         s_axis_tdata;   // [31:0] value
  logic [OP_W-1:0]            s_axis_tuser;   // [1:0] op
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [VALUE_W+COUNT_W-1:0] m_axis_tdata;   // [31:0] result_value, [39:32] entry_count
  logic [STATUS_W-1:0]        m_axis_tuser;   // [1:0] status

  pq_scoreboard sb;
  logic         steady;       // when set, neither side inserts bubbles
  int unsigned  quiet_cycles;

  min_priority_queue_scan #(
    .CAPACITY (CAP)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Result side: random backpressure set at the falling edge, beats checked at the rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Hang detector: counts cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("hang: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.awaited.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, value);
    @(negedge clk_i);
  endtask

  // Mostly ties and extremes, so the min search sees equal keys and sign boundaries.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return $urandom();
    if (sel < 75) return VALUE_W'($signed($urandom_range(6)) - 3);
    if (sel < 85) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (sel < 93) return 32'h8000_0000 + $urandom_range(15);
    return 32'h7fff_ffff - $urandom_range(15);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_mix_e mix);
    int unsigned sel;
    sel = $urandom_range(99);
    case (mix)
      MIX_GROW:   return (sel < 85) ? OP_INSERT : (sel < 93) ? OP_DELETE :
                         (sel < 98) ? OP_PEEK : OP_UNUSED;
      MIX_SHRINK: return (sel < 13) ? OP_INSERT : (sel < 88) ? OP_DELETE :
                         (sel < 98) ? OP_PEEK : OP_UNUSED;
      default:    return (sel < 40) ? OP_INSERT : (sel < 75) ? OP_DELETE :
                         (sel < 95) ? OP_PEEK : OP_UNUSED;
    endcase
  endfunction

  task automatic run_traffic(traffic_mix_e mix, int unsigned beats);
    repeat (beats) send_request(pick_op(mix), pick_value());
  endtask

  initial begin
    sb            = new();
    steady        = 1'b0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // errors and no-op on the empty queue
    send_request(OP_PEEK, 32'hdead_beef);
    send_request(OP_DELETE, 32'h1234_5678);
    send_request(OP_UNUSED, 32'hffff_ffff);
    // extremes, with the most negative value stored twice to test the tie rule
    send_request(OP_INSERT, 32'd5);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'hffff_ffff);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'd5);
    send_request(OP_PEEK, 32'h0);
    send_request(OP_UNUSED, 32'h0);
    // drain in order of value; the shift must keep arrival order of the rest
    repeat (7) send_request(OP_DELETE, $urandom());
    send_request(OP_DELETE, 32'h0);
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_INSERT, 32'haaaa_aaaa);
    send_request(OP_PEEK, 32'h0);
    send_request(OP_DELETE, 32'h0);

    // fill past capacity, drain past empty, mixed traffic with no bubbles, then fill and drain again
    run_traffic(MIX_GROW, 220);
    run_traffic(MIX_SHRINK, 230);
    steady = 1'b1;
    run_traffic(MIX_BALANCED, 150);
    steady = 1'b0;
    run_traffic(MIX_GROW, 200);
    run_traffic(MIX_SHRINK, 200);
    s_axis_tvalid = 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts, %0d deletes, %0d peeks and %0d unused ops; %0d results seen.",
             sb.n_insert, sb.n_delete, sb.n_peek, sb.n_unused, sb.n_results);
    $display("Store filled %0d times, %0d overflow and %0d empty results; %0d mismatches.",
             sb.n_full, sb.n_overflow, sb.n_empty, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_ram.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/mpq_dp.sv
hw/rtl/min_priority_queue_scan.sv
sim/testbench.sv
